// File: rtl/loss_pkg.sv
// Shared types, codes and helpers of the Lamport-ordered shared store.
`default_nettype none
package loss_pkg;

  // Input item kinds
  localparam logic [2:0] KindWrite = 3'd0;
  localparam logic [2:0] KindCas   = 3'd1;
  localparam logic [2:0] KindRecv  = 3'd2;
  localparam logic [2:0] KindDrain = 3'd3;
  localparam logic [2:0] KindSub   = 3'd4;

  // Result item kinds
  localparam logic [1:0] OutSend   = 2'd0;
  localparam logic [1:0] OutNotify = 2'd1;
  localparam logic [1:0] OutFail   = 2'd2;
  localparam logic [1:0] OutDrop   = 2'd3;

  localparam logic [31:0] ClockMax = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_CAS,
    OP_RECV,
    OP_DRAIN,
    OP_SUB
  } op_e;

  // Command handed from front to back
  typedef struct packed {
    op_e         op;
    logic [5:0]  var_id;
    logic [31:0] value;
    logic [31:0] expected;
    logic [31:0] msg_clock;
    logic [3:0]  source;
    logic [15:0] mask;
  } cmd_t;

  // One variable entry
  typedef struct packed {
    logic        registered;
    logic [15:0] mask;
    logic [31:0] value;
  } var_word_t;

  // One queued update, key is {clk, src}
  typedef struct packed {
    logic [31:0] clk;
    logic [3:0]  src;
    logic [5:0]  var_id;
    logic [31:0] value;
  } heap_ent_t;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  dest;
    logic [5:0]  var_id;
    logic [31:0] value;
    logic [31:0] clk;
    logic        last;
  } out_t;

  // Saturating clock increment
  function automatic logic [31:0] clock_inc(input logic [31:0] c);
    return (c == ClockMax) ? c : c + 32'd1;
  endfunction

endpackage
`default_nettype wire

// File: rtl/loss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module loss_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [W-1:0]             rdata_o
);
  logic [W-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// File: rtl/loss_cmd_fifo.sv
// Two-entry command queue between front and back.
`default_nettype none
module loss_cmd_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] wdata_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              valid_o,
  output logic      [W-1:0] rdata_o
);
  logic [W-1:0] buf_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = buf_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= wdata_i;
    end
  end
endmodule
`default_nettype wire

// File: rtl/loss_front.sv
// Input side: accepts items, decodes their kind and queues commands.
`default_nettype none
module loss_front (
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [127:0]       s_tdata,
  input  wire logic [2:0]         s_tuser,
  input  wire logic               busy_i,
  input  wire logic               full_i,
  output logic                    push_o,
  output loss_pkg::cmd_t          cmd_o
);
  logic           known;
  loss_pkg::op_e  op;

  assign s_tready = !full_i && !busy_i;

  // Decode kind, drop unused codes
  always_comb begin
    known = 1'b1;
    op    = loss_pkg::OP_WRITE;
    unique case (s_tuser)
      loss_pkg::KindWrite: op    = loss_pkg::OP_WRITE;
      loss_pkg::KindCas:   op    = loss_pkg::OP_CAS;
      loss_pkg::KindRecv:  op    = loss_pkg::OP_RECV;
      loss_pkg::KindDrain: op    = loss_pkg::OP_DRAIN;
      loss_pkg::KindSub:   op    = loss_pkg::OP_SUB;
      default:             known = 1'b0;
    endcase
  end

  // Unpack payload
  assign cmd_o.op        = op;
  assign cmd_o.var_id    = s_tdata[5:0];
  assign cmd_o.value     = s_tdata[37:6];
  assign cmd_o.expected  = s_tdata[69:38];
  assign cmd_o.msg_clock = s_tdata[101:70];
  assign cmd_o.source    = s_tdata[105:102];
  assign cmd_o.mask      = s_tdata[121:106];

  assign push_o = s_tvalid && s_tready && known;
endmodule
`default_nettype wire

// File: rtl/loss_back.sv
// Execution side: variable store, update queue, clock and result sequencing.
`default_nettype none
module loss_back #(
  parameter int NUM_VARS    = 64,
  parameter int NUM_NODES   = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [3:0]     cfg_wdata_i,
  input  wire logic           cmd_valid_i,
  input  wire loss_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  output logic                busy_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output loss_pkg::out_t      out_o
);
  localparam int VarW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int HaW  = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [15:0] NodeMask =
    (NUM_NODES >= 16) ? 16'hFFFF : 16'((32'd1 << NUM_NODES) - 32'd1);

  localparam logic [3:0] SClear = 4'd0;
  localparam logic [3:0] SIdle  = 4'd1;
  localparam logic [3:0] SVar   = 4'd2;
  localparam logic [3:0] SExec  = 4'd3;
  localparam logic [3:0] SSend  = 4'd4;
  localparam logic [3:0] SNote  = 4'd5;
  localparam logic [3:0] SIns   = 4'd6;
  localparam logic [3:0] SPut   = 4'd7;
  localparam logic [3:0] SDrh   = 4'd8;
  localparam logic [3:0] SDrv   = 4'd9;
  localparam logic [3:0] SDre   = 4'd10;
  localparam logic [3:0] SDfin  = 4'd11;

  // Variable id modulo NUM_VARS by restoring subtraction
  function automatic logic [VarW-1:0] var_index(input logic [5:0] id);
    logic [16:0] r;
    r = 17'(id);
    for (int i = 5; i >= 0; i--) begin
      if (r >= (17'(NUM_VARS) << i)) r = r - (17'(NUM_VARS) << i);
    end
    return VarW'(r);
  endfunction

  logic [3:0]           state_q, state_d;
  logic [VarW-1:0]      clr_q, clr_d;
  logic [3:0]           rank_q;
  logic [31:0]          clock_q, clock_d;
  loss_pkg::cmd_t       cmd_q, cmd_d;
  logic                 cur_reg_q, cur_reg_d;
  logic [15:0]          cur_mask_q, cur_mask_d;
  logic [31:0]          cur_val_q, cur_val_d;
  logic [15:0]          pend_q, pend_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [HaW-1:0]       pos_q, pos_d;
  logic [HaW-1:0]       idx_q, idx_d;
  loss_pkg::heap_ent_t  ent_q, ent_d;
  logic                 out_vld_q, out_vld_d;
  loss_pkg::out_t       out_q, out_d;
  logic                 hold_vld_q, hold_vld_d;
  loss_pkg::out_t       hold_q, hold_d;

  logic                 var_we, var_re;
  logic [VarW-1:0]      var_waddr, var_raddr;
  loss_pkg::var_word_t  var_wdata, var_rdata;
  logic                 heap_we, heap_re;
  logic [HaW-1:0]       heap_waddr, heap_raddr;
  loss_pkg::heap_ent_t  heap_wdata, heap_rdata, new_ent;

  logic                 can_emit, emit;
  logic [3:0]           sel;
  logic [15:0]          rest;
  logic                 drain_last, drain_adv;
  logic [31:0]          mclk;

  loss_ram #(.W($bits(loss_pkg::var_word_t)), .DEPTH(NUM_VARS)) u_var_ram (
    .clk_i   (clk_i),
    .we_i    (var_we),
    .waddr_i (var_waddr),
    .wdata_i (var_wdata),
    .re_i    (var_re),
    .raddr_i (var_raddr),
    .rdata_o (var_rdata)
  );

  loss_ram #(.W($bits(loss_pkg::heap_ent_t)), .DEPTH(QUEUE_DEPTH)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (heap_wdata),
    .re_i    (heap_re),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rdata)
  );

  assign can_emit    = !out_vld_q || out_ready_i;
  assign busy_o      = (state_q == SClear);
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  assign new_ent.clk    = cmd_q.msg_clock;
  assign new_ent.src    = cmd_q.source;
  assign new_ent.var_id = cmd_q.var_id;
  assign new_ent.value  = cmd_q.value;

  // Lowest pending subscriber
  always_comb begin
    sel = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (pend_q[i]) sel = 4'(i);
    end
    rest = pend_q & ~(16'd1 << sel);
  end

  assign drain_last = ((CntW'(idx_q) + CntW'(1)) == cnt_q);
  assign mclk       = (clock_q > ent_q.clk) ? clock_q : ent_q.clk;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    clock_d    = clock_q;
    cmd_d      = cmd_q;
    cur_reg_d  = cur_reg_q;
    cur_mask_d = cur_mask_q;
    cur_val_d  = cur_val_q;
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    idx_d      = idx_q;
    ent_d      = ent_q;
    hold_vld_d = hold_vld_q;
    hold_d     = hold_q;
    cmd_pop_o  = 1'b0;
    var_we     = 1'b0;
    var_waddr  = var_index(cmd_q.var_id);
    var_wdata  = '0;
    var_re     = 1'b0;
    var_raddr  = var_index(cmd_i.var_id);
    heap_we    = 1'b0;
    heap_waddr = pos_q;
    heap_wdata = new_ent;
    heap_re    = 1'b0;
    heap_raddr = pos_q - HaW'(1);
    emit       = 1'b0;
    out_d      = out_q;
    drain_adv  = 1'b0;

    unique case (state_q)
      SClear: begin
        var_we    = 1'b1;
        var_waddr = clr_q;
        clr_d     = clr_q + VarW'(1);
        if (clr_q == VarW'(NUM_VARS - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          var_re    = 1'b1;
          state_d   = SVar;
        end
      end
      SVar: begin
        cur_reg_d  = var_rdata.registered;
        cur_mask_d = var_rdata.mask;
        cur_val_d  = var_rdata.value;
        state_d    = SExec;
      end
      SExec: begin
        unique case (cmd_q.op)
          loss_pkg::OP_WRITE, loss_pkg::OP_CAS: begin
            if (cmd_q.op == loss_pkg::OP_CAS && cur_val_q != cmd_q.expected) begin
              // Report mismatch, change nothing
              if (can_emit) begin
                emit    = 1'b1;
                out_d   = '{loss_pkg::OutFail, 4'd0, cmd_q.var_id, cur_val_q,
                            clock_q, 1'b1};
                state_d = SIdle;
              end
            end else begin
              clock_d   = loss_pkg::clock_inc(clock_q);
              var_we    = 1'b1;
              var_wdata = '{cur_reg_q, cur_mask_q, cmd_q.value};
              pend_d    = cur_mask_q & NodeMask & ~(16'd1 << rank_q);
              if ((cur_mask_q & NodeMask & ~(16'd1 << rank_q)) != 16'd0) begin
                state_d = SSend;
              end else if (cur_reg_q) begin
                state_d = SNote;
              end else begin
                state_d = SIdle;
              end
            end
          end
          loss_pkg::OP_RECV: begin
            if (cnt_q == CntW'(QUEUE_DEPTH)) begin
              if (can_emit) begin
                emit    = 1'b1;
                out_d   = '{loss_pkg::OutDrop, 4'd0, cmd_q.var_id, cmd_q.value,
                            cmd_q.msg_clock, 1'b1};
                state_d = SIdle;
              end
            end else if (cnt_q == '0) begin
              heap_we    = 1'b1;
              heap_waddr = '0;
              cnt_d      = cnt_q + CntW'(1);
              state_d    = SIdle;
            end else begin
              pos_d      = HaW'(cnt_q);
              heap_re    = 1'b1;
              heap_raddr = HaW'(cnt_q - CntW'(1));
              state_d    = SIns;
            end
          end
          loss_pkg::OP_DRAIN: begin
            if (cnt_q == '0) begin
              state_d = SIdle;
            end else begin
              idx_d      = '0;
              heap_re    = 1'b1;
              heap_raddr = '0;
              state_d    = SDrh;
            end
          end
          loss_pkg::OP_SUB: begin
            var_we    = 1'b1;
            var_wdata = '{1'b1, cmd_q.mask, cur_val_q};
            state_d   = SIdle;
          end
          default: state_d = SIdle;
        endcase
      end
      SSend: begin
        if (can_emit) begin
          emit   = 1'b1;
          out_d  = '{loss_pkg::OutSend, sel, cmd_q.var_id, cmd_q.value, clock_q,
                     (rest == 16'd0) && !cur_reg_q};
          pend_d = rest;
          if (rest == 16'd0) state_d = cur_reg_q ? SNote : SIdle;
        end
      end
      SNote: begin
        if (can_emit) begin
          emit    = 1'b1;
          out_d   = '{loss_pkg::OutNotify, 4'd0, cmd_q.var_id, cmd_q.value,
                      clock_q, 1'b1};
          state_d = SIdle;
        end
      end
      SIns: begin
        // Shift larger key up one slot, equal keys stay ahead
        if ({heap_rdata.clk, heap_rdata.src} > {cmd_q.msg_clock, cmd_q.source}) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          pos_d      = pos_q - HaW'(1);
          if (pos_q == HaW'(1)) begin
            state_d = SPut;
          end else begin
            heap_re    = 1'b1;
            heap_raddr = pos_q - HaW'(2);
          end
        end else begin
          heap_we = 1'b1;
          cnt_d   = cnt_q + CntW'(1);
          state_d = SIdle;
        end
      end
      SPut: begin
        heap_we = 1'b1;
        cnt_d   = cnt_q + CntW'(1);
        state_d = SIdle;
      end
      SDrh: begin
        ent_d     = heap_rdata;
        var_re    = 1'b1;
        var_raddr = var_index(heap_rdata.var_id);
        state_d   = SDrv;
      end
      SDrv: begin
        clock_d   = loss_pkg::clock_inc(mclk);
        var_we    = 1'b1;
        var_waddr = var_index(ent_q.var_id);
        var_wdata = '{var_rdata.registered, var_rdata.mask, ent_q.value};
        if (var_rdata.registered) begin
          state_d = SDre;
        end else begin
          drain_adv = 1'b1;
        end
      end
      SDre: begin
        // Send the held notify and hold this one until the next is known
        if (!hold_vld_q || can_emit) begin
          if (hold_vld_q) begin
            emit  = 1'b1;
            out_d = hold_q;
          end
          hold_vld_d = 1'b1;
          hold_d     = '{loss_pkg::OutNotify, 4'd0, ent_q.var_id, ent_q.value,
                         clock_q, 1'b0};
          drain_adv  = 1'b1;
        end
      end
      SDfin: begin
        // Send the final notify of the drain
        if (can_emit) begin
          emit       = 1'b1;
          out_d      = hold_q;
          out_d.last = 1'b1;
          hold_vld_d = 1'b0;
          state_d    = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase

    // Advance to the next queued update or finish the drain
    if (drain_adv) begin
      if (drain_last) begin
        cnt_d   = '0;
        state_d = hold_vld_d ? SDfin : SIdle;
      end else begin
        idx_d      = idx_q + HaW'(1);
        heap_re    = 1'b1;
        heap_raddr = idx_q + HaW'(1);
        state_d    = SDrh;
      end
    end
  end

  // Output register
  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SClear;
      clr_q      <= '0;
      rank_q     <= 4'd0;
      clock_q    <= 32'd0;
      cnt_q      <= '0;
      pend_q     <= 16'd0;
      out_vld_q  <= 1'b0;
      hold_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      clock_q    <= clock_d;
      cnt_q      <= cnt_d;
      pend_q     <= pend_d;
      out_vld_q  <= out_vld_d;
      hold_vld_q <= hold_vld_d;
      if (cfg_we_i) rank_q <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    cur_reg_q  <= cur_reg_d;
    cur_mask_q <= cur_mask_d;
    cur_val_q  <= cur_val_d;
    pos_q      <= pos_d;
    idx_q      <= idx_d;
    ent_q      <= ent_d;
    out_q      <= out_d;
    hold_q     <= hold_d;
  end
endmodule
`default_nettype wire

// File: rtl/lamport_ordered_shared_store_top.sv
// Top level of one Lamport-clock node of a replicated variable store.
// Input items arrive on the s_* stream: tuser carries the kind, tdata the
// variable, values, timestamp, source node and subscriber mask. Results leave
// on the m_* stream with tuser as result kind and tlast on the final result
// caused by an input item. node_rank is written through cfg_we_i/cfg_wdata_i.
// A front decoder queues commands in a two-entry queue; a back sequencer runs
// them one at a time against a variable RAM and an update-queue RAM.
// Each item passes the command queue; the sequencer then pops it and reads
// the variable, takes the variable word, and executes. A write then emits its
// results one by one; a received update compares queued entries one at a time
// (with a put step when it passes them all); a drain reads each queued entry
// and writes its variable, then sends a notify for each registered variable.
// After reset the variable RAM is cleared, one entry a cycle, across all NUM_VARS
// entries; s_tready stays low meanwhile. The clock, queue count and rank reset
// to zero. A stalled receiver holds the output register and the sequencer
// waits; the front keeps taking items until the command queue is full.
`default_nettype none
module lamport_ordered_shared_store_top #(
  parameter int NUM_VARS    = 64,
  parameter int NUM_NODES   = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [3:0]   cfg_wdata_i,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // var_id[5:0] value[37:6] expected[69:38] msg_clock[101:70]
  // source_node[105:102] subscriber_mask[121:106], rest zero
  input  wire logic [127:0] s_tdata,
  // kind[2:0]
  input  wire logic [2:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // dest_node[3:0] out_var[9:4] out_value[41:10] out_clock[73:42], rest zero
  output logic [79:0]       m_tdata,
  // out_kind[1:0]
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);
  logic           busy, full, push, pop, cmd_valid;
  loss_pkg::cmd_t cmd_in, cmd_out;
  loss_pkg::out_t res;

  loss_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .busy_i   (busy),
    .full_i   (full),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  loss_cmd_fifo #(.W($bits(loss_pkg::cmd_t))) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .rdata_o (cmd_out)
  );

  loss_back #(
    .NUM_VARS    (NUM_VARS),
    .NUM_NODES   (NUM_NODES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (pop),
    .busy_o      (busy),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_o       (res)
  );

  // Pack result item
  assign m_tdata = {6'd0, res.clk, res.value, res.var_id, res.dest};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;
endmodule
`default_nettype wire

// File: test/tb_lamport_ordered_shared_store_top.sv
// Self-checking testbench for the Lamport-ordered shared store node.
`default_nettype none
module tb_lamport_ordered_shared_store_top;

  localparam int NumVars   = 64;
  localparam int NumNodes  = 16;
  localparam int QueueSize = 16;
  localparam int CycleCap  = 600000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  dest;
    logic [5:0]  var_id;
    logic [31:0] value;
    logic [31:0] clk;
    logic        last;
  } result_t;

  typedef struct {
    logic [2:0]  kind;
    logic [5:0]  var_id;
    logic [31:0] value;
    logic [31:0] expected;
    logic [31:0] msg_clock;
    logic [3:0]  source;
    logic [15:0] mask;
  } item_t;

  // Directed row: the item plus an optional result typed in by hand
  typedef struct {
    item_t   it;
    logic    has_fixed;
    result_t fixed;
  } row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [3:0]    cfg_wdata_i = '0;
  logic          s_tvalid = 1'b0;
  wire           s_tready;
  logic [127:0]  s_tdata = '0;
  logic [2:0]    s_tuser = '0;
  wire           m_tvalid;
  logic          m_tready = 1'b0;
  wire  [79:0]   m_tdata;
  wire  [1:0]    m_tuser;
  wire           m_tlast;

  lamport_ordered_shared_store_top #(
    .NUM_VARS(NumVars), .NUM_NODES(NumNodes), .QUEUE_DEPTH(QueueSize)
  ) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .s_tvalid, .s_tready, .s_tdata,
    .s_tuser, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  always #4 clk_i = ~clk_i;

  // Predictor state
  logic [31:0] store_val [NumVars];
  logic [15:0] store_mask[NumVars];
  logic        store_reg [NumVars];
  logic [31:0] lamport;
  logic [35:0] pend_key [QueueSize];
  logic [37:0] pend_data[QueueSize];
  int          pend_cnt;
  logic [3:0]  my_rank;

  result_t     awaited[$];
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off = 1'b0;

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c == loss_pkg::ClockMax) ? c : c + 32'd1;
  endfunction

  function automatic result_t mk(input logic [1:0] k, input logic [3:0] d,
                                 input logic [5:0] v, input logic [31:0] val,
                                 input logic [31:0] c);
    result_t r;
    r.kind = k; r.dest = d; r.var_id = v; r.value = val; r.clk = c; r.last = 1'b0;
    return r;
  endfunction

  // Local store of a value and its fan-out to subscribers and notify
  task automatic local_update(input logic [5:0] v, input logic [31:0] val,
                              ref result_t res[$]);
    lamport = bump(lamport);
    store_val[v] = val;
    for (int n = 0; n < NumNodes && n < 16; n++)
      if (store_mask[v][n] && n != my_rank)
        res.push_back(mk(loss_pkg::OutSend, n[3:0], v, val, lamport));
    if (store_reg[v]) res.push_back(mk(loss_pkg::OutNotify, '0, v, val, lamport));
  endtask

  // Work out the results of one item and advance the predicted state
  task automatic predict_item(input item_t it);
    result_t     res[$];
    logic [35:0] key;
    int          pos;
    logic [31:0] kc;
    logic [5:0]  pv;
    logic [31:0] pval;
    case (it.kind)
      loss_pkg::KindWrite: local_update(it.var_id, it.value, res);
      loss_pkg::KindCas:
        if (store_val[it.var_id] == it.expected) local_update(it.var_id, it.value, res);
        else res.push_back(mk(loss_pkg::OutFail, '0, it.var_id, store_val[it.var_id],
                              lamport));
      loss_pkg::KindRecv:
        if (pend_cnt >= QueueSize) begin
          res.push_back(mk(loss_pkg::OutDrop, '0, it.var_id, it.value, it.msg_clock));
        end else begin
          key = {it.msg_clock, it.source};
          pos = pend_cnt;
          while (pos > 0 && pend_key[pos-1] > key) begin
            pend_key[pos] = pend_key[pos-1];
            pend_data[pos] = pend_data[pos-1];
            pos--;
          end
          pend_key[pos] = key;
          pend_data[pos] = {it.var_id, it.value};
          pend_cnt++;
        end
      loss_pkg::KindDrain: begin
        for (int i = 0; i < pend_cnt; i++) begin
          kc = pend_key[i][35:4];
          pv = pend_data[i][37:32];
          pval = pend_data[i][31:0];
          lamport = bump((lamport > kc) ? lamport : kc);
          store_val[pv] = pval;
          if (store_reg[pv]) res.push_back(mk(loss_pkg::OutNotify, '0, pv, pval, lamport));
        end
        pend_cnt = 0;
      end
      loss_pkg::KindSub: begin
        store_mask[it.var_id] = it.mask;
        store_reg[it.var_id] = 1'b1;
      end
      default: ;
    endcase
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) awaited.push_back(res[i]);
  endtask

  // Drive one item and wait for its handshake
  task automatic offer(input item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= {6'd0, it.mask, it.source, it.msg_clock, it.expected, it.value,
                 it.var_id};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict_item(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Wait until every expected result has arrived, then let the block settle
  task automatic settle();
    s_tvalid <= 1'b0;
    while (awaited.size() > 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_rank(input logic [3:0] r);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= r;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    my_rank = r;
  endtask

  function automatic item_t item(input logic [2:0] k, input logic [5:0] v,
                                 input logic [31:0] val, input logic [31:0] ex,
                                 input logic [31:0] mc, input logic [3:0] src,
                                 input logic [15:0] m);
    item_t it;
    it.kind = k; it.var_id = v; it.value = val; it.expected = ex;
    it.msg_clock = mc; it.source = src; it.mask = m;
    return it;
  endfunction

  // Random item, mostly well-formed traffic on a few hot variables
  function automatic item_t rand_item();
    item_t it;
    int    p;
    p = $urandom_range(99);
    it = item(3'($urandom_range(4)), 6'($urandom_range(7)), $urandom, $urandom,
              $urandom, 4'($urandom), 16'($urandom));
    if ($urandom_range(3) == 0) it.var_id = 6'($urandom);
    if (p < 30) it.kind = loss_pkg::KindWrite;
    else if (p < 45) it.kind = loss_pkg::KindCas;
    else if (p < 75) it.kind = loss_pkg::KindRecv;
    else if (p < 83) it.kind = loss_pkg::KindDrain;
    else if (p < 93) it.kind = loss_pkg::KindSub;
    else it.kind = 3'd5 + 3'($urandom_range(2));
    if (it.kind == loss_pkg::KindCas && $urandom_range(1))
      it.expected = store_val[it.var_id];
    if (it.kind == loss_pkg::KindRecv && $urandom_range(1))
      it.msg_clock = lamport + 32'($urandom_range(20));
    if (it.kind == loss_pkg::KindSub && $urandom_range(1))
      it.mask = 16'(1 << $urandom_range(15));
    return it;
  endfunction

  // Check results against the oldest expectation
  always @(posedge clk_i) begin
    result_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[3:0], m_tdata[9:4], m_tdata[41:10], m_tdata[73:42],
             m_tlast};
      results_seen++;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = awaited.pop_front();
        if (got !== want || m_tdata[79:74] !== '0) begin
          errors++;
          $display("%0t: mismatch expected kind %0d dest %0d var %0d val %h clk %h last %b",
                   $time, want.kind, want.dest, want.var_id, want.value, want.clk,
                   want.last);
          $display("%0t:          actual kind %0d dest %0d var %0d val %h clk %h last %b",
                   $time, got.kind, got.dest, got.var_id, got.value, got.clk, got.last);
        end
      end
    end
  end

  // Receiver: random stall, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_off) m_tready <= 1'b0;
    else m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  // Run limit
  always @(posedge clk_i) begin
    if (cycles > CycleCap) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Long receiver hold-off counted in its own process
  task automatic long_hold();
    hold_off = 1'b1;
    repeat (300) @(negedge clk_i);
    hold_off = 1'b0;
  endtask

  row_t table_rows[$];

  initial begin
    item_t it;
    row_t  row;
    for (int i = 0; i < NumVars; i++) begin
      store_val[i] = '0; store_mask[i] = '0; store_reg[i] = 1'b0;
    end
    lamport = '0; pend_cnt = 0; my_rank = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    set_rank(4'd0);

    // Directed rows
    row.has_fixed = 1'b1;
    row.it = item(loss_pkg::KindCas, 6'd63, 32'h1, 32'h5, '0, '0, '0);
    row.fixed = mk(loss_pkg::OutFail, '0, 6'd63, 32'h0, 32'h0); row.fixed.last = 1'b1;
    table_rows.push_back(row);
    row.has_fixed = 1'b0;
    row.it = item(loss_pkg::KindWrite, 6'd0, 32'h8000_0000, '0, '0, '0, '0);
    table_rows.push_back(row);
    row.it = item(loss_pkg::KindSub, 6'd1, '0, '0, '0, '0, 16'hFFFF);
    table_rows.push_back(row);
    row.it = item(loss_pkg::KindWrite, 6'd1, 32'h7FFF_FFFF, '0, '0, '0, '0);
    table_rows.push_back(row);
    row.it = item(loss_pkg::KindSub, 6'd2, '0, '0, '0, '0, 16'h0);
    table_rows.push_back(row);
    row.it = item(loss_pkg::KindCas, 6'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, '0, '0, '0);
    table_rows.push_back(row);
    row.it = item(loss_pkg::KindRecv, 6'd2, 32'hA, '0, 32'd50, 4'd15, '0);
    table_rows.push_back(row);
    row.it = item(loss_pkg::KindRecv, 6'd2, 32'hB, '0, 32'd50, 4'd3, '0);
    table_rows.push_back(row);
    row.it = item(loss_pkg::KindRecv, 6'd1, 32'hC, '0, 32'd50, 4'd3, '0);
    table_rows.push_back(row);
    row.it = item(loss_pkg::KindRecv, 6'd2, 32'hD, '0, 32'd10, 4'd0, '0);
    table_rows.push_back(row);
    row.it = item(loss_pkg::KindDrain, '0, '0, '0, '0, '0, '0); table_rows.push_back(row);
    row.it = item(loss_pkg::KindDrain, '0, '0, '0, '0, '0, '0); table_rows.push_back(row);
    row.it = item(3'd7, 6'd2, 32'h1, '0, '0, '0, 16'hFFFF); table_rows.push_back(row);
    row.it = item(loss_pkg::KindRecv, 6'd2, 32'h5, '0, 32'hFFFF_FFFF, 4'd9, '0);
    table_rows.push_back(row);
    row.it = item(loss_pkg::KindRecv, 6'd5, 32'h7, '0, 32'd3, 4'd1, '0);
    table_rows.push_back(row);
    row.it = item(loss_pkg::KindDrain, '0, '0, '0, '0, '0, '0); table_rows.push_back(row);
    row.it = item(loss_pkg::KindWrite, 6'd2, 32'h6, '0, '0, '0, '0);
    table_rows.push_back(row);
    foreach (table_rows[i]) begin
      offer(table_rows[i].it);
      if (table_rows[i].has_fixed && awaited[awaited.size()-1] !== table_rows[i].fixed)
        begin
        errors++;
        $display("%0t: predictor row %0d expected %h actual %h", $time, i,
                 table_rows[i].fixed, awaited[awaited.size()-1]);
      end
    end
    settle();

    // Queue-full drop with back-pressure: fill the queue while the receiver holds off
    set_rank(4'd15);
    fork long_hold(); join_none
    for (int i = 0; i < QueueSize + 3; i++)
      offer(item(loss_pkg::KindRecv, 6'($urandom), $urandom, '0, $urandom,
                 4'($urandom), '0));
    for (int i = 0; i < 6; i++)
      offer(item(loss_pkg::KindWrite, 6'd1, $urandom, '0, '0, '0, '0));
    offer(item(loss_pkg::KindDrain, '0, '0, '0, '0, '0, '0));
    settle();

    // Random phases under varied rank and idling
    for (int ph = 0; ph < 4; ph++) begin
      set_rank(ph == 0 ? 4'd0 : ph == 3 ? 4'd15 : 4'($urandom));
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int i = 0; i < 120; i++) begin
        it = rand_item();
        offer(it);
      end
      offer(item(loss_pkg::KindDrain, '0, '0, '0, '0, '0, '0));
      settle();
    end

    $display("Covered %0d items and %0d results: writes, compare-exchange, ordered",
             items_sent, results_seen);
    $display("queue drains, drops, subscriptions, rank changes and stalls.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
rtl/loss_pkg.sv
rtl/loss_ram.sv
rtl/loss_cmd_fifo.sv
rtl/loss_front.sv
rtl/loss_back.sv
rtl/lamport_ordered_shared_store_top.sv
test/tb_lamport_ordered_shared_store_top.sv
